// File: src/bary_pkg.sv
// Shared constants and types for the barycentric weight pipeline.
package bary_pkg;

    localparam int BARY_COORD_BITS       = 16;
    localparam int BARY_WEIGHT_FRAC_BITS = 16;
    localparam int BARY_FIELD_BITS       = 16;
    localparam int BARY_WEIGHT_BITS      = 20;
    localparam int BARY_LANES            = 3;

    typedef struct packed {
        logic [BARY_LANES-1:0] neg;
        logic [BARY_LANES-1:0] ovf;
        logic                  in_tri;
        logic                  degen;
    } bary_flags_t;

endpackage

// File: src/triangle_barycentric_weights.sv
// Stages: four front stages, twenty divider cells, one output stage.
// Throughput: one item per cycle while the output is not stalled (out_stall low).
// Each stage moves when empty or when its successor moves, so bubbles close up under stall.
// Reset (rst_n low, asynchronous) clears every stage valid bit; payload registers keep data.
// Nothing carries from one item to the next, so reset leaves no other state to clear.
module triangle_barycentric_weights #(
    parameter int COORD_BITS       = bary_pkg::BARY_COORD_BITS,
    parameter int WEIGHT_FRAC_BITS = bary_pkg::BARY_WEIGHT_FRAC_BITS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic signed [bary_pkg::BARY_FIELD_BITS-1:0] vertex_a_x,
    input  logic signed [bary_pkg::BARY_FIELD_BITS-1:0] vertex_a_y,
    input  logic signed [bary_pkg::BARY_FIELD_BITS-1:0] vertex_b_x,
    input  logic signed [bary_pkg::BARY_FIELD_BITS-1:0] vertex_b_y,
    input  logic signed [bary_pkg::BARY_FIELD_BITS-1:0] vertex_c_x,
    input  logic signed [bary_pkg::BARY_FIELD_BITS-1:0] vertex_c_y,
    input  logic signed [bary_pkg::BARY_FIELD_BITS-1:0] point_x,
    input  logic signed [bary_pkg::BARY_FIELD_BITS-1:0] point_y,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic signed [bary_pkg::BARY_WEIGHT_BITS-1:0] weight_a,
    output logic signed [bary_pkg::BARY_WEIGHT_BITS-1:0] weight_b,
    output logic signed [bary_pkg::BARY_WEIGHT_BITS-1:0] weight_c,
    output logic                                        inside_res,
    output logic                                        degenerate
);
    import bary_pkg::*;

    // Determinant magnitudes need twice the coordinate width plus three bits.
    localparam int CW = (COORD_BITS > 16) ? 17 : COORD_BITS;
    localparam int MW = 2 * CW + 3;
    localparam int QB = BARY_WEIGHT_BITS;

    // Saturation limits of the signed weight field.
    localparam logic [QB-1:0] W_MAX = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] W_MIN = {1'b1, {(QB-1){1'b0}}};

    logic [7:0][BARY_FIELD_BITS-1:0] coord;

    // Divider chain: index 0 is the front end's output, index QB the last cell's output.
    logic [QB:0]                   ch_valid;
    logic [QB:0]                   ch_en;
    logic [MW-1:0]                 ch_den   [QB+1];
    logic [BARY_LANES-1:0][MW-1:0] ch_rem   [QB+1];
    logic [BARY_LANES-1:0][QB-1:0] ch_xlo   [QB+1];
    logic [BARY_LANES-1:0][QB-1:0] ch_q     [QB+1];
    bary_flags_t                   ch_flags [QB+1];

    logic                          out_v_reg;
    logic                          en_out;
    logic [BARY_LANES-1:0][QB-1:0] weight_reg;
    logic [BARY_LANES-1:0][QB-1:0] weight_next;
    logic                          inside_reg;
    logic                          degen_reg;

    assign coord = {point_y, point_x, vertex_c_y, vertex_c_x,
                    vertex_b_y, vertex_b_x, vertex_a_y, vertex_a_x};

    bary_front #(
        .COORD_BITS       (COORD_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .MAG_BITS         (MW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .coord     (coord),
        .en_down   (ch_en[0]),
        .valid_out (ch_valid[0]),
        .den       (ch_den[0]),
        .rem       (ch_rem[0]),
        .xlo       (ch_xlo[0]),
        .flags     (ch_flags[0])
    );

    // The quotient bits start from zero; each cell shifts one new bit in at the bottom.
    assign ch_q[0] = '0;

    for (genvar k = 0; k < QB; k++)
    begin : g_cell
        bary_div_cell #(
            .MAG_BITS (MW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (ch_valid[k]),
            .en_up     (ch_en[k]),
            .en_down   (ch_en[k+1]),
            .valid_out (ch_valid[k+1]),
            .den_in    (ch_den[k]),
            .rem_in    (ch_rem[k]),
            .xlo_in    (ch_xlo[k]),
            .q_in      (ch_q[k]),
            .flags_in  (ch_flags[k]),
            .den_out   (ch_den[k+1]),
            .rem_out   (ch_rem[k+1]),
            .xlo_out   (ch_xlo[k+1]),
            .q_out     (ch_q[k+1]),
            .flags_out (ch_flags[k+1])
        );
    end

    // The output register frees when it is empty or its item is taken.
    assign en_out    = !out_v_reg || !out_stall;
    assign ch_en[QB] = en_out;

    // Apply the sign and saturate. A quotient at or above 2^QB was flagged in the front end;
    // a negative weight may reach exactly the most negative code. A zero determinant forces
    // all weights to zero.
    always_comb
    begin
        for (int l = 0; l < BARY_LANES; l++)
        begin
            if (ch_flags[QB].degen)
            begin
                weight_next[l] = '0;
            end
            else if (ch_flags[QB].ovf[l])
            begin
                weight_next[l] = ch_flags[QB].neg[l] ? W_MIN : W_MAX;
            end
            else if (ch_flags[QB].neg[l])
            begin
                weight_next[l] = (ch_q[QB][l] > W_MIN) ? W_MIN : (~ch_q[QB][l] + 1'b1);
            end
            else
            begin
                weight_next[l] = ch_q[QB][l][QB-1] ? W_MAX : ch_q[QB][l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_v_reg <= ch_valid[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            weight_reg <= weight_next;
            inside_reg <= ch_flags[QB].in_tri;
            degen_reg  <= ch_flags[QB].degen;
        end
    end

    assign out_valid  = out_v_reg;
    assign weight_a   = weight_reg[0];
    assign weight_b   = weight_reg[1];
    assign weight_c   = weight_reg[2];
    assign inside_res = inside_reg;
    assign degenerate = degen_reg;

    // The input only stalls when the whole chain is full behind a held result.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output side can take an item");

    // A degenerate triangle yields zero weights and no inside flag.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |->
            (weight_a == '0 && weight_b == '0 && weight_c == '0 && !inside_res))
        else $error("degenerate result carries nonzero weights or inside flag");

    // A point inside the triangle never gets a negative weight.
    a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && inside_res) |-> (!weight_a[QB-1] && !weight_b[QB-1] && !weight_c[QB-1]))
        else $error("inside point with a negative weight");

    // A result taken while no item is in the chain leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !ch_valid[QB]) |=> !out_valid)
        else $error("output valid without an item behind it");

endmodule

// File: src/bary_front.sv
// Front end: coordinate differences, products, determinants and divider setup.
module bary_front #(
    parameter int COORD_BITS       = 16,
    parameter int WEIGHT_FRAC_BITS = 16,
    parameter int MAG_BITS         = 2 * ((COORD_BITS > 16) ? 17 : COORD_BITS) + 3
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic [7:0][bary_pkg::BARY_FIELD_BITS-1:0]     coord,
    input  logic                                          en_down,
    output logic                                          valid_out,
    output logic [MAG_BITS-1:0]                           den,
    output logic [bary_pkg::BARY_LANES-1:0][MAG_BITS-1:0] rem,
    output logic [bary_pkg::BARY_LANES-1:0][bary_pkg::BARY_WEIGHT_BITS-1:0] xlo,
    output bary_pkg::bary_flags_t                         flags
);
    import bary_pkg::*;

    localparam int CW = (COORD_BITS > 16) ? 17 : COORD_BITS;
    localparam int LB = (COORD_BITS > 16) ? 16 : COORD_BITS;
    localparam int DF = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int MW = MAG_BITS;
    localparam int XW = MW + WEIGHT_FRAC_BITS;
    localparam int QB = BARY_WEIGHT_BITS;

    logic [3:0] v_reg;
    logic [3:0] v_next;
    logic [4:0] en;

    logic signed [CW-1:0] c [8];
    logic signed [DF-1:0] dif_reg  [10];
    logic signed [DF-1:0] dif_next [10];
    logic signed [PW-1:0] prod_reg  [8];
    logic signed [PW-1:0] prod_next [8];
    logic signed [MW-1:0] det_reg  [4];
    logic signed [MW-1:0] det_next [4];

    logic [MW-1:0]                 mag [4];
    logic [XW-1:0]                 xw  [BARY_LANES];
    logic [XW-1:0]                 hi  [BARY_LANES];
    logic [MW-1:0]                 den_next;
    logic [BARY_LANES-1:0][MW-1:0] rem_next;
    logic [BARY_LANES-1:0][QB-1:0] xlo_next;
    bary_flags_t                   flags_next;
    logic                          same_sign;

    logic [MW-1:0]                 den_reg;
    logic [BARY_LANES-1:0][MW-1:0] rem_reg;
    logic [BARY_LANES-1:0][QB-1:0] xlo_reg;
    bary_flags_t                   flags_reg;

    // A stage moves when it is empty or the stage after it moves.
    always_comb
    begin
        en[4] = en_down;
        for (int i = 3; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next = {v_reg[2:0], in_valid};
    end

    assign in_stall  = !en[0];
    assign valid_out = v_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // Coordinates no wider than the field are sign-extended; wider ones read it as unsigned.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (COORD_BITS > 16)
            begin
                c[i] = CW'($unsigned(coord[i][LB-1:0]));
            end
            else
            begin
                c[i] = CW'($signed(coord[i][LB-1:0]));
            end
        end
        dif_next[0] = DF'(c[2]) - DF'(c[6]);
        dif_next[1] = DF'(c[3]) - DF'(c[7]);
        dif_next[2] = DF'(c[4]) - DF'(c[6]);
        dif_next[3] = DF'(c[5]) - DF'(c[7]);
        dif_next[4] = DF'(c[0]) - DF'(c[6]);
        dif_next[5] = DF'(c[1]) - DF'(c[7]);
        dif_next[6] = DF'(c[2]) - DF'(c[0]);
        dif_next[7] = DF'(c[3]) - DF'(c[1]);
        dif_next[8] = DF'(c[4]) - DF'(c[0]);
        dif_next[9] = DF'(c[5]) - DF'(c[1]);
    end

    always_comb
    begin
        prod_next[0] = PW'(dif_reg[0]) * PW'(dif_reg[3]);
        prod_next[1] = PW'(dif_reg[2]) * PW'(dif_reg[1]);
        prod_next[2] = PW'(dif_reg[2]) * PW'(dif_reg[5]);
        prod_next[3] = PW'(dif_reg[4]) * PW'(dif_reg[3]);
        prod_next[4] = PW'(dif_reg[4]) * PW'(dif_reg[1]);
        prod_next[5] = PW'(dif_reg[0]) * PW'(dif_reg[5]);
        prod_next[6] = PW'(dif_reg[6]) * PW'(dif_reg[9]);
        prod_next[7] = PW'(dif_reg[8]) * PW'(dif_reg[7]);
        for (int i = 0; i < 4; i++)
        begin
            det_next[i] = MW'(prod_reg[2*i]) - MW'(prod_reg[2*i+1]);
        end
    end

    // Magnitudes, overflow test against 2^QB times the divisor, and the sign flags.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = det_reg[i][MW-1] ? (~det_reg[i] + 1'b1) : det_reg[i];
        end
        den_next         = mag[3];
        flags_next.degen = (det_reg[3] == '0);
        same_sign        = 1'b1;
        for (int l = 0; l < BARY_LANES; l++)
        begin
            xw[l]             = {mag[l], {WEIGHT_FRAC_BITS{1'b0}}};
            hi[l]             = xw[l] >> QB;
            flags_next.ovf[l] = (hi[l] >= XW'(mag[3]));
            flags_next.neg[l] = det_reg[l][MW-1] ^ det_reg[3][MW-1];
            rem_next[l]       = hi[l][MW-1:0];
            xlo_next[l]       = xw[l][QB-1:0];
            if ((det_reg[l] == '0) || flags_next.neg[l])
            begin
                same_sign = 1'b0;
            end
        end
        flags_next.in_tri = same_sign && !flags_next.degen;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dif_reg <= dif_next;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
        end
        if (en[2])
        begin
            det_reg <= det_next;
        end
        if (en[3])
        begin
            den_reg   <= den_next;
            rem_reg   <= rem_next;
            xlo_reg   <= xlo_next;
            flags_reg <= flags_next;
        end
    end

    assign den   = den_reg;
    assign rem   = rem_reg;
    assign xlo   = xlo_reg;
    assign flags = flags_reg;

endmodule

// File: src/bary_div_cell.sv
// One restoring division cell: one quotient bit for each of the three weights.
module bary_div_cell #(
    parameter int MAG_BITS = 37
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          valid_in,
    output logic                                          en_up,
    input  logic                                          en_down,
    output logic                                          valid_out,
    input  logic [MAG_BITS-1:0]                           den_in,
    input  logic [bary_pkg::BARY_LANES-1:0][MAG_BITS-1:0] rem_in,
    input  logic [bary_pkg::BARY_LANES-1:0][bary_pkg::BARY_WEIGHT_BITS-1:0] xlo_in,
    input  logic [bary_pkg::BARY_LANES-1:0][bary_pkg::BARY_WEIGHT_BITS-1:0] q_in,
    input  bary_pkg::bary_flags_t                         flags_in,
    output logic [MAG_BITS-1:0]                           den_out,
    output logic [bary_pkg::BARY_LANES-1:0][MAG_BITS-1:0] rem_out,
    output logic [bary_pkg::BARY_LANES-1:0][bary_pkg::BARY_WEIGHT_BITS-1:0] xlo_out,
    output logic [bary_pkg::BARY_LANES-1:0][bary_pkg::BARY_WEIGHT_BITS-1:0] q_out,
    output bary_pkg::bary_flags_t                         flags_out
);
    import bary_pkg::*;

    localparam int MW = MAG_BITS;
    localparam int QB = BARY_WEIGHT_BITS;

    logic                          v_reg;
    logic [MW-1:0]                 den_reg;
    logic [BARY_LANES-1:0][MW-1:0] rem_reg;
    logic [BARY_LANES-1:0][MW-1:0] rem_next;
    logic [BARY_LANES-1:0][QB-1:0] xlo_reg;
    logic [BARY_LANES-1:0][QB-1:0] xlo_next;
    logic [BARY_LANES-1:0][QB-1:0] q_reg;
    logic [BARY_LANES-1:0][QB-1:0] q_next;
    bary_flags_t                   flags_reg;
    logic [MW:0]                   r2  [BARY_LANES];
    logic [MW:0]                   dif [BARY_LANES];
    logic                          ge  [BARY_LANES];

    assign en_up = !v_reg || en_down;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        for (int l = 0; l < BARY_LANES; l++)
        begin
            r2[l]       = {rem_in[l], xlo_in[l][QB-1]};
            dif[l]      = r2[l] - {1'b0, den_in};
            ge[l]       = (r2[l] >= {1'b0, den_in});
            rem_next[l] = ge[l] ? dif[l][MW-1:0] : r2[l][MW-1:0];
            xlo_next[l] = {xlo_in[l][QB-2:0], 1'b0};
            q_next[l]   = {q_in[l][QB-2:0], ge[l]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en_up)
        begin
            v_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_up)
        begin
            den_reg   <= den_in;
            rem_reg   <= rem_next;
            xlo_reg   <= xlo_next;
            q_reg     <= q_next;
            flags_reg <= flags_in;
        end
    end

    assign valid_out = v_reg;
    assign den_out   = den_reg;
    assign rem_out   = rem_reg;
    assign xlo_out   = xlo_reg;
    assign q_out     = q_reg;
    assign flags_out = flags_reg;

endmodule

// File: test/tb_triangle_barycentric_weights.sv
// Self-checking testbench for the barycentric weight pipeline.
module tb_triangle_barycentric_weights;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = bary_pkg::BARY_FIELD_BITS;
    localparam int WB = bary_pkg::BARY_WEIGHT_BITS;
    localparam int LATENCY = 25;
    localparam int RANDOM_ITEMS = 650;
    localparam longint CYCLE_LIMIT = 400000;

    // One input item of the block.
    typedef struct packed {
        logic signed [FB-1:0] ax, ay, bx, by, cx, cy, px, py;
    } tri_item_t;

    // One result item of the block.
    typedef struct packed {
        logic signed [WB-1:0] wa, wb, wc;
        logic                 in_tri;
        logic                 degen;
    } weights_t;

    int error_count = 0;

    // Prints one line per mismatch and keeps the count.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Scoreboard: computes the weights of each accepted item and holds them in order.
    class weights_scoreboard;
        weights_t pending_weights[$];

        // Scales num/den into Q3.16, truncates toward zero and saturates to 20 bits.
        function automatic logic signed [WB-1:0] quotient_weight(longint num, longint den);
            longint unsigned mn, md, q;
            bit neg;
            mn = num < 0 ? -num : num;
            md = den < 0 ? -den : den;
            q = (mn << bary_pkg::BARY_WEIGHT_FRAC_BITS) / md;
            neg = (num < 0) != (den < 0);
            if (neg)
                return (q > (64'd1 << (WB - 1))) ? -(64'sd1 << (WB - 1)) : -longint'(q);
            return (q > ((64'd1 << (WB - 1)) - 1)) ? ((64'sd1 << (WB - 1)) - 1) : longint'(q);
        endfunction

        function automatic int sign_of(longint v);
            return (v > 0) - (v < 0);
        endfunction

        // Notes an accepted input item by computing its expected weights.
        function void note_item(tri_item_t t);
            longint ax, ay, bx, by, cx, cy, px, py, d0, d1, d2, dt;
            weights_t w;
            ax = t.ax; ay = t.ay; bx = t.bx; by = t.by;
            cx = t.cx; cy = t.cy; px = t.px; py = t.py;
            d0 = (bx - px) * (cy - py) - (cx - px) * (by - py);
            d1 = (cx - px) * (ay - py) - (ax - px) * (cy - py);
            d2 = (ax - px) * (by - py) - (bx - px) * (ay - py);
            dt = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
            w = '0;
            if (dt == 0) begin
                w.degen = 1'b1;
            end else begin
                w.wa = quotient_weight(d0, dt);
                w.wb = quotient_weight(d1, dt);
                w.wc = quotient_weight(d2, dt);
                w.in_tri = sign_of(d0) == sign_of(dt) && sign_of(d1) == sign_of(dt)
                           && sign_of(d2) == sign_of(dt);
            end
            pending_weights.push_back(w);
        endfunction

        // Compares one accepted result with the oldest expectation.
        task check_result(weights_t got);
            weights_t exp_w;
            if (pending_weights.size() == 0) begin
                report_mismatch("result with no expectation waiting");
                return;
            end
            exp_w = pending_weights.pop_front();
            if (got.wa !== exp_w.wa)
                report_mismatch($sformatf("weight_a %0d, expected %0d", got.wa, exp_w.wa));
            if (got.wb !== exp_w.wb)
                report_mismatch($sformatf("weight_b %0d, expected %0d", got.wb, exp_w.wb));
            if (got.wc !== exp_w.wc)
                report_mismatch($sformatf("weight_c %0d, expected %0d", got.wc, exp_w.wc));
            if (got.in_tri !== exp_w.in_tri)
                report_mismatch($sformatf("inside_res %b, expected %b", got.in_tri, exp_w.in_tri));
            if (got.degen !== exp_w.degen)
                report_mismatch($sformatf("degenerate %b, expected %b", got.degen, exp_w.degen));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    tri_item_t drive_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [WB-1:0] weight_a, weight_b, weight_c;
    logic inside_res, degenerate;

    // The idle rate for both sides is 34 in 100; it drops to zero for a quiet stretch.
    int idle_pct = 34;
    longint cycle_count = 0;
    weights_scoreboard sb = new();

    triangle_barycentric_weights u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .vertex_a_x(drive_item.ax), .vertex_a_y(drive_item.ay),
        .vertex_b_x(drive_item.bx), .vertex_b_y(drive_item.by),
        .vertex_c_x(drive_item.cx), .vertex_c_y(drive_item.cy),
        .point_x(drive_item.px), .point_y(drive_item.py),
        .out_valid(out_valid), .out_stall(out_stall),
        .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
        .inside_res(inside_res), .degenerate(degenerate)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Receiver side: stall is chosen at each edge; a result counts when valid and not stalled,
    // sampled on the values that stood before the edge's own updates.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{weight_a, weight_b, weight_c, inside_res, degenerate});
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    // A run that never drains is caught here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Presents one item and holds it until the block takes it. Valid is never dropped
    // between back-to-back items, so it gets one assignment per edge.
    task automatic send_item(input tri_item_t t);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        drive_item <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(t);
    endtask

    // A coordinate that mostly stays small, with full-range and edge values at times.
    function automatic logic signed [FB-1:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return $urandom;
            default: return $signed(16'($urandom_range(2047))) - 16'sd1024;
        endcase
    endfunction

    // Random triangle: mostly ordinary, some degenerate, some with P at a vertex, near the centroid or far out.
    function automatic tri_item_t random_triangle();
        tri_item_t t;
        t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        case ($urandom_range(9))
            0: begin t.cx = t.ax; t.cy = t.ay; end
            1: begin t.bx = t.ax; t.by = t.ay; t.cx = t.ax; t.cy = t.ay; end
            2: begin t.px = t.bx; t.py = t.by; end
            3: begin
                // P near the centroid of the triangle, so inside is set often.
                t.px = 16'((32'(t.ax) + 32'(t.bx) + 32'(t.cx)) / 3);
                t.py = 16'((32'(t.ay) + 32'(t.by) + 32'(t.cy)) / 3);
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_weights.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        tri_item_t t;
        logic signed [FB-1:0] ext[4];
        ext = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a plain inside case, the point on an edge, at a vertex and outside.
        send_item('{0, 0, 160, 0, 0, 160, 16, 16});
        send_item('{0, 0, 160, 0, 0, 160, 80, 0});
        send_item('{0, 0, 160, 0, 0, 160, 0, 0});
        send_item('{0, 0, 160, 0, 0, 160, -16, -16});
        // Clockwise winding, where all signs flip.
        send_item('{0, 0, 0, 160, 160, 0, 16, 16});
        // Zero triangle determinant: collinear and coincident vertices.
        send_item('{0, 0, 16, 16, 32, 32, 5, 7});
        send_item('{3, 3, 3, 3, 3, 3, 3, 3});
        // Tiny triangle with a far point saturates the weights both ways.
        send_item('{0, 0, 1, 0, 0, 1, 16'sh7FFF, 16'sh7FFF});
        send_item('{0, 0, 1, 0, 0, 1, 16'sh8000, 16'sh7FFF});
        // Huge triangle with a point near a vertex: tiny positive weights that truncate to one LSB.
        send_item('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                    16'sh8001, 16'sh8001});
        // Extreme coordinates in every field.
        for (int i = 0; i < 12; i++) begin
            for (int k = 0; k < 8; k++)
                t[k*FB +: FB] = ext[$urandom_range(3)];
            send_item(t);
        end

        // Hold off until every expected result has come, then go on.
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct = (n >= 250 && n < 350) ? 0 : 34;
            send_item(random_triangle());
        end
        idle_pct = 34;

        drain_results();
        repeat (LATENCY + 5) @(posedge clk);
        if (error_count == 0 && sb.pending_weights.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
